// File: rtl/refcount_handle_allocator_core_macros.svh
// assertion macros for the checker file of the handle allocator
// expects clk_i and rst_ni in the scope of the file that includes it
`ifndef REFCOUNT_HANDLE_ALLOCATOR_CORE_MACROS_SVH
`define REFCOUNT_HANDLE_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define RHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the rising clock edge outside reset
`define RHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rha_pkg.sv
// shared types and codes of the reference-counted handle allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rha_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RETAIN  = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NOP     = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_LIVE = 2'd2,
    ST_SAT      = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // result control handed from the engine to the output register
  typedef struct packed {
    logic    load;
    logic    freed;
    status_e status;
  } res_ctl_t;

endpackage

`default_nettype wire

// File: rtl/rha_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module rha_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/rha_exec.sv
// read-modify-write engine: sequencer, free list head, high-water mark
// depends on rha_pkg; drives the ports of one rha_ram instance
`timescale 1ns / 1ps
`default_nettype none

module rha_exec #(
  parameter int NUM_HANDLES = 1024,
  parameter int COUNT_BITS  = 16,
  localparam int HW = $clog2(NUM_HANDLES + 1),
  localparam int AW = $clog2(NUM_HANDLES),
  localparam int MW = (COUNT_BITS > HW) ? COUNT_BITS : HW,
  localparam int DW = MW + 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        opcode_i,
  input  wire logic [HW-1:0]     handle_i,
  input  wire logic              res_busy_i,
  output rha_pkg::res_ctl_t      res_o,
  output logic      [HW-1:0]     res_handle_o,
  output logic                   ram_we_o,
  output logic      [AW-1:0]     ram_waddr_o,
  output logic      [DW-1:0]     ram_wdata_o,
  output logic                   ram_re_o,
  output logic      [AW-1:0]     ram_raddr_o,
  input  wire logic [DW-1:0]     ram_rdata_i
);

  localparam logic [HW-1:0]         NullH    = HW'(NUM_HANDLES);
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CountOne = COUNT_BITS'(1);

  rha_pkg::state_e  state_q, state_d;
  rha_pkg::opcode_e op_q, op_d;
  logic [HW-1:0]    h_q, h_d;
  logic [HW-1:0]    free_head_q, free_head_d;
  logic [HW-1:0]    high_water_q, high_water_d;

  // stored word: live flag on top, count or free link below
  logic                  rd_live;
  logic [COUNT_BITS-1:0] rd_count;
  logic [HW-1:0]         rd_link;
  logic                  h_live;
  logic [HW-1:0]         got;

  assign rd_live  = ram_rdata_i[DW-1];
  assign rd_count = ram_rdata_i[COUNT_BITS-1:0];
  assign rd_link  = ram_rdata_i[HW-1:0];
  // entries at or above the high-water mark were never written
  assign h_live   = (h_q < high_water_q) && rd_live;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rha_pkg::S_IDLE;
      free_head_q  <= NullH;
      high_water_q <= '0;
    end else begin
      state_q      <= state_d;
      free_head_q  <= free_head_d;
      high_water_q <= high_water_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    h_q  <= h_d;
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    h_d          = h_q;
    free_head_d  = free_head_q;
    high_water_d = high_water_q;
    in_ready_o   = 1'b0;
    ram_re_o     = 1'b0;
    ram_raddr_o  = handle_i[AW-1:0];
    ram_we_o     = 1'b0;
    ram_waddr_o  = h_q[AW-1:0];
    ram_wdata_o  = '0;
    res_o        = '{load: 1'b0, freed: 1'b0, status: rha_pkg::ST_OK};
    res_handle_o = NullH;
    got          = NullH;

    unique case (state_q)
      rha_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d     = rha_pkg::opcode_e'(opcode_i);
          h_d      = handle_i;
          ram_re_o = 1'b1;
          // allocate reads the head entry to learn the next link
          if (rha_pkg::opcode_e'(opcode_i) == rha_pkg::OP_ALLOC) begin
            ram_raddr_o = free_head_q[AW-1:0];
          end
          state_d = rha_pkg::S_EXEC;
        end
      end

      rha_pkg::S_EXEC: begin
        if (!res_busy_i) begin
          state_d    = rha_pkg::S_IDLE;
          res_o.load = 1'b1;
          case (op_q) inside
            rha_pkg::OP_ALLOC: begin
              if (free_head_q != NullH) begin
                got         = free_head_q;
                free_head_d = (rd_link < NullH) ? rd_link : NullH;
              end else if (high_water_q < NullH) begin
                got          = high_water_q;
                high_water_d = high_water_q + 1'b1;
              end
              if (got == NullH) begin
                res_o.status = rha_pkg::ST_FULL;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = got[AW-1:0];
                ram_wdata_o = {1'b1, MW'(CountOne)};
              end
              res_handle_o = got;
            end

            rha_pkg::OP_RETAIN, rha_pkg::OP_RELEASE: begin
              res_handle_o = h_q;
              if (h_q == NullH) begin
                res_o.status = rha_pkg::ST_OK;
              end else if (!h_live) begin
                res_o.status = rha_pkg::ST_NOT_LIVE;
              end else if (op_q == rha_pkg::OP_RETAIN) begin
                if (rd_count == CountMax) begin
                  res_o.status = rha_pkg::ST_SAT;
                end else begin
                  ram_we_o    = 1'b1;
                  ram_wdata_o = {1'b1, MW'(rd_count + CountOne)};
                end
              end else if (rd_count > CountOne) begin
                ram_we_o    = 1'b1;
                ram_wdata_o = {1'b1, MW'(rd_count - CountOne)};
              end else begin
                // last reference: push onto the free list
                ram_we_o    = 1'b1;
                ram_wdata_o = {1'b0, MW'(free_head_q)};
                free_head_d = h_q;
                res_o.freed = 1'b1;
              end
            end

            default: begin
              res_handle_o = NullH;
            end
          endcase
        end
      end

      default: begin
        state_d = rha_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/refcount_handle_allocator_core.sv
// Reference-counted handle allocator. In the accept cycle the entry for the
// handle (or the free list head) is read from the single-port-read count
// memory; in the execute state the entry is modified, written back and the
// result loaded into the output register, and no new transfer is accepted
// until that is done. The execute state waits while a previous result sits
// unaccepted in the output register. There is no clearing pass after reset:
// entries at or above the high-water mark are treated as never used, so the
// block accepts transfers right out of reset.
// depends on rha_pkg, rha_ram and rha_exec
`timescale 1ns / 1ps
`default_nettype none

module refcount_handle_allocator_core #(
  parameter int NUM_HANDLES = 1024,
  parameter int COUNT_BITS  = 16,
  localparam int HW = $clog2(NUM_HANDLES + 1),
  localparam int AW = $clog2(NUM_HANDLES),
  localparam int MW = (COUNT_BITS > HW) ? COUNT_BITS : HW,
  localparam int DW = MW + 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [1:0]    opcode_i,
  input  wire logic [HW-1:0] handle_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic      [HW-1:0] result_handle_o,
  output logic               freed_o,
  output logic      [1:0]    status_o
);

  rha_pkg::res_ctl_t res_ctl;
  logic [HW-1:0]     res_handle;
  logic              res_busy;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  logic              out_valid_q, out_valid_d;
  logic [HW-1:0]     handle_q, handle_d;
  logic              freed_q, freed_d;
  rha_pkg::status_e  status_q, status_d;

  rha_ram #(
    .WIDTH (DW),
    .DEPTH (NUM_HANDLES)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rha_exec #(
    .NUM_HANDLES (NUM_HANDLES),
    .COUNT_BITS  (COUNT_BITS)
  ) u_exec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .handle_i     (handle_i),
    .res_busy_i   (res_busy),
    .res_o        (res_ctl),
    .res_handle_o (res_handle),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  // output register frees up in the same cycle its transfer completes
  assign res_busy = out_valid_q && !out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    handle_d    = handle_q;
    freed_d     = freed_q;
    status_d    = status_q;
    if (res_ctl.load) begin
      out_valid_d = 1'b1;
      handle_d    = res_handle;
      freed_d     = res_ctl.freed;
      status_d    = res_ctl.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    handle_q <= handle_d;
    freed_q  <= freed_d;
    status_q <= status_d;
  end

  assign out_valid_o     = out_valid_q;
  assign result_handle_o = handle_q;
  assign freed_o         = freed_q;
  assign status_o        = status_q;

endmodule

`default_nettype wire

// File: rtl/rha_checker.sv
// port-level assertions for refcount_handle_allocator_core, bound to the top
// depends on rha_pkg and refcount_handle_allocator_core_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "refcount_handle_allocator_core_macros.svh"

module rha_checker #(
  parameter int NUM_HANDLES = 1024,
  localparam int HW = $clog2(NUM_HANDLES + 1)
) (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_o,
  input wire logic [1:0]    opcode_i,
  input wire logic [HW-1:0] handle_i,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire logic [HW-1:0] result_handle_o,
  input wire logic          freed_o,
  input wire logic [1:0]    status_o
);

  localparam logic [HW-1:0] NullH = HW'(NUM_HANDLES);

  // every accepted transfer keeps the engine busy in its execute state, so ready drops after an accept
  `RHA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")

  `RHA_ASSERT_NOW(a_freed_is_ok, out_valid_o && freed_o, (status_o == rha_pkg::ST_OK) && (result_handle_o != NullH), "freed result with bad status or null handle")

  `RHA_ASSERT_NOW(a_full_is_null, out_valid_o && (status_o == rha_pkg::ST_FULL), (result_handle_o == NullH) && !freed_o, "pool full result carries a handle")

  // handles past the null value can only come back as not live
  `RHA_ASSERT_NOW(a_high_handle, out_valid_o && (result_handle_o > NullH), status_o == rha_pkg::ST_NOT_LIVE, "out-of-range handle not flagged")

  `RHA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(result_handle_o) && $stable(status_o), "stalled result changed")

endmodule

bind refcount_handle_allocator_core rha_checker #(
  .NUM_HANDLES (NUM_HANDLES)
) u_rha_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .opcode_i        (opcode_i),
  .handle_i        (handle_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .result_handle_o (result_handle_o),
  .freed_o         (freed_o),
  .status_o        (status_o)
);

`default_nettype wire

// File: tb/refcount_handle_allocator_checker.sv
// result checker for the handle allocator: watches both channels, predicts each result
// and compares it field by field; depends on rha_pkg only
`timescale 1ns / 1ps

module refcount_handle_allocator_checker #(
  parameter int NUM_HANDLES = 1024,
  parameter int COUNT_BITS  = 16,
  localparam int HW = $clog2(NUM_HANDLES + 1),
  localparam int MW = (COUNT_BITS > HW) ? COUNT_BITS : HW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  logic [1:0]    opcode_i,
  input  logic [HW-1:0] handle_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  logic [HW-1:0] result_handle_i,
  input  logic          freed_i,
  input  logic [1:0]    status_i,
  output int            fail_count_o,
  output int            pending_o,
  output int            checked_o,
  output int            freed_seen_o,
  output int            full_seen_o,
  output int            sat_seen_o,
  output int            dead_seen_o
);

  localparam logic [HW-1:0] NULL_HANDLE = HW'(NUM_HANDLES);
  localparam logic [MW-1:0] COUNT_MAX   = MW'((64'd1 << COUNT_BITS) - 64'd1);

  typedef struct packed {
    logic [HW-1:0]    handle;
    logic             freed;
    rha_pkg::status_e status;
  } handle_result_t;

  // count of a live handle, or next-free link of a freed one
  logic [MW-1:0]  count_or_next [NUM_HANDLES];
  bit             live [NUM_HANDLES];
  logic [HW-1:0]  free_top;
  logic [HW-1:0]  next_fresh;
  handle_result_t due_results [$];

  int fail_count = 0;
  int pending = 0;
  int checked = 0;
  int freed_seen = 0;
  int full_seen = 0;
  int sat_seen = 0;
  int dead_seen = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;
  assign checked_o    = checked;
  assign freed_seen_o = freed_seen;
  assign full_seen_o  = full_seen;
  assign sat_seen_o   = sat_seen;
  assign dead_seen_o  = dead_seen;

  function automatic handle_result_t apply_handle_op(rha_pkg::opcode_e op, logic [HW-1:0] h);
    handle_result_t r;
    logic [HW-1:0]  got;
    logic [MW-1:0]  link;
    r = '{handle: NULL_HANDLE, freed: 1'b0, status: rha_pkg::ST_OK};
    case (op)
      rha_pkg::OP_ALLOC: begin
        got = NULL_HANDLE;
        if (free_top < NULL_HANDLE) begin
          got = free_top;
          link = count_or_next[got];
          free_top = (link < MW'(NUM_HANDLES)) ? link[HW-1:0] : NULL_HANDLE;
        end else if (next_fresh < NULL_HANDLE) begin
          got = next_fresh;
          next_fresh = next_fresh + 1'b1;
        end
        if (got == NULL_HANDLE) begin
          r.status = rha_pkg::ST_FULL;
        end else begin
          count_or_next[got] = MW'(1);
          live[got] = 1'b1;
          r.handle = got;
        end
      end
      rha_pkg::OP_NOP: begin
      end
      default: begin
        if (h != NULL_HANDLE) begin
          r.handle = h;
          if (h > NULL_HANDLE || !live[h]) begin
            r.status = rha_pkg::ST_NOT_LIVE;
          end else if (op == rha_pkg::OP_RETAIN) begin
            if (count_or_next[h] >= COUNT_MAX) begin
              count_or_next[h] = COUNT_MAX;
              r.status = rha_pkg::ST_SAT;
            end else begin
              count_or_next[h] = count_or_next[h] + 1'b1;
            end
          end else if (count_or_next[h] > MW'(1)) begin
            count_or_next[h] = count_or_next[h] - 1'b1;
          end else begin
            // last reference gone: push onto the free list
            count_or_next[h] = MW'(free_top);
            free_top = h;
            live[h] = 1'b0;
            r.freed = 1'b1;
          end
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    handle_result_t want;
    if (!rst_ni) begin
      free_top = NULL_HANDLE;
      next_fresh = '0;
      foreach (live[i]) begin
        live[i] = 1'b0;
        count_or_next[i] = '0;
      end
      due_results.delete();
      pending = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        due_results.push_back(apply_handle_op(rha_pkg::opcode_e'(opcode_i), handle_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result transfer, handle %0d freed %0d status %0d",
                   $time, result_handle_i, freed_i, status_i);
        end else begin
          want = due_results.pop_front();
          checked++;
          if (result_handle_i !== want.handle) begin
            fail_count++;
            $display("%0t: result_handle expected %0d, actual %0d",
                     $time, want.handle, result_handle_i);
          end
          if (freed_i !== want.freed) begin
            fail_count++;
            $display("%0t: freed expected %0d, actual %0d", $time, want.freed, freed_i);
          end
          if (status_i !== want.status) begin
            fail_count++;
            $display("%0t: status expected %0d, actual %0d", $time, want.status, status_i);
          end
          if (want.freed) freed_seen++;
          case (want.status)
            rha_pkg::ST_FULL:     full_seen++;
            rha_pkg::ST_SAT:      sat_seen++;
            rha_pkg::ST_NOT_LIVE: dead_seen++;
            default: begin
            end
          endcase
        end
      end
      pending = due_results.size();
    end
  end

endmodule

// File: tb/refcount_handle_allocator_core_tb.sv
// top of the handle allocator testbench: clock, reset, stimulus and verdict
// depends on rha_pkg, refcount_handle_allocator_core and refcount_handle_allocator_checker
`timescale 1ns / 1ps

module refcount_handle_allocator_core_tb;

  localparam int NUM_HANDLES = 1024;
  localparam int COUNT_BITS  = 16;
  localparam int HW          = $clog2(NUM_HANDLES + 1);
  localparam logic [HW-1:0] NULL_HANDLE = HW'(NUM_HANDLES);
  localparam logic [HW-1:0] TOP_HANDLE  = '1;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  rha_pkg::opcode_e opcode_i = rha_pkg::OP_NOP;
  logic [HW-1:0]    handle_i = '0;
  logic             out_ready_i = 1'b0;
  logic             in_ready_o;
  logic             out_valid_o;
  logic [HW-1:0]    result_handle_o;
  logic             freed_o;
  logic [1:0]       status_o;

  int fail_count;
  int pending;
  int checked;
  int freed_seen;
  int full_seen;
  int sat_seen;
  int dead_seen;

  bit idling_on = 1'b1;
  int allocs_sent = 0;
  int cycle_count = 0;

  refcount_handle_allocator_core #(
    .NUM_HANDLES(NUM_HANDLES),
    .COUNT_BITS (COUNT_BITS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .handle_i       (handle_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_handle_o(result_handle_o),
    .freed_o        (freed_o),
    .status_o       (status_o)
  );

  refcount_handle_allocator_checker #(
    .NUM_HANDLES(NUM_HANDLES),
    .COUNT_BITS (COUNT_BITS)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .opcode_i       (opcode_i),
    .handle_i       (handle_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_handle_i(result_handle_o),
    .freed_i        (freed_o),
    .status_i       (status_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .freed_seen_o   (freed_seen),
    .full_seen_o    (full_seen),
    .sat_seen_o     (sat_seen),
    .dead_seen_o    (dead_seen)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold-off to back the block up
  int  rx_done = 0;
  int  long_hold = 0;
  int  burst_left = 0;
  bit  held_once = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) rx_done <= rx_done + 1;
      if (!held_once && rx_done == 200) begin
        held_once <= 1'b1;
        long_hold <= 300;
        out_ready_i <= 1'b0;
      end else if (long_hold > 0) begin
        long_hold <= long_hold - 1;
        out_ready_i <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left <= burst_left - 1;
        out_ready_i <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        burst_left <= $urandom_range(0, 9);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_item(input rha_pkg::opcode_e op, input logic [HW-1:0] h);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    handle_i <= h;
    if (op == rha_pkg::OP_ALLOC) allocs_sent++;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // mostly retain/release of handles that have been handed out, some noise
  task automatic send_random(input int n);
    int               r;
    int               span;
    rha_pkg::opcode_e op;
    logic [HW-1:0]    h;
    repeat (n) begin
      r = $urandom_range(0, 99);
      op = (r < 38) ? rha_pkg::OP_ALLOC : (r < 66) ? rha_pkg::OP_RETAIN :
           (r < 96) ? rha_pkg::OP_RELEASE : rha_pkg::OP_NOP;
      span = (allocs_sent < NUM_HANDLES) ? allocs_sent : NUM_HANDLES;
      if (span == 0) span = 1;
      r = $urandom_range(0, 99);
      if (op == rha_pkg::OP_ALLOC || op == rha_pkg::OP_NOP) h = HW'($urandom());
      else if (r < 5) h = NULL_HANDLE;
      else if (r < 10) h = HW'($urandom_range(NUM_HANDLES + 1, (1 << HW) - 1));
      else h = HW'($urandom_range(0, span - 1));
      send_item(op, h);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: untouched, null and out-of-range handles, lifo reuse, unused opcode
    send_item(rha_pkg::OP_RETAIN, '0);
    send_item(rha_pkg::OP_RELEASE, NULL_HANDLE);
    send_item(rha_pkg::OP_RETAIN, TOP_HANDLE);
    send_item(rha_pkg::OP_NOP, TOP_HANDLE);
    send_item(rha_pkg::OP_ALLOC, '0);
    send_item(rha_pkg::OP_ALLOC, TOP_HANDLE);
    send_item(rha_pkg::OP_ALLOC, 11'h2AA);
    send_item(rha_pkg::OP_RETAIN, 11'd0);
    send_item(rha_pkg::OP_RELEASE, 11'd0);
    send_item(rha_pkg::OP_RELEASE, 11'd0);
    send_item(rha_pkg::OP_RELEASE, 11'd0);
    send_item(rha_pkg::OP_RELEASE, 11'd2);
    send_item(rha_pkg::OP_ALLOC, 11'h555);
    send_item(rha_pkg::OP_ALLOC, '0);
    send_item(rha_pkg::OP_ALLOC, '0);
    send_item(rha_pkg::OP_RETAIN, NULL_HANDLE + 11'd1);
    send_item(rha_pkg::OP_RELEASE, 11'd1);
    send_item(rha_pkg::OP_RETAIN, NULL_HANDLE);
    send_item(rha_pkg::OP_NOP, '0);
    wait_drained();

    send_random(450);
    wait_drained();

    // exhaust the pool: free list first, then fresh handles, then refusals
    repeat (NUM_HANDLES + 6) send_item(rha_pkg::OP_ALLOC, HW'($urandom()));

    send_random(200);
    idling_on = 1'b0;
    send_random(100);
    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("%0d results checked: %0d frees, %0d full-pool refusals, %0d saturated retains,",
             checked, freed_seen, full_seen, sat_seen);
    $display("%0d touches of dead handles, with stalls on both channels and a long output hold",
             dead_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
